// ===== hdl/eif_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equilibrium index finder package
// Field widths and the sum type used by the finder; its element store is generic.
// ----------------------------------------------------------------------------
package eif_pkg;

    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 64;
    localparam int INDEX_W  = 6;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic        [INDEX_W-1:0]  t_index;

endpackage

// ===== hdl/equilibrium_index_finder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equilibrium index finder
// Stores an array of signed 32-bit elements and reports every index whose
// left-side sum equals its right-side sum.
// ----------------------------------------------------------------------------
// Element requests are taken without stall while the store fills and the
// running total accumulates; elements beyond MAX_ELEMENTS are dropped. After
// the request flagged final_element the block stops taking requests and scans
// the store: ST_RD starts the read, then for each stored element one 64-bit
// adder forms 2*prefix + element for the compare (ST_ADDA) and then the next
// 2*prefix (ST_ADDB), fed from the store's single registered read port.
// ST_ADDA holds while an earlier match waits for a stalled output, and ST_FIN
// delivers the last result once the output is free. Matches leave in ascending
// order and the last carries run_end; an array with no match yields a single
// result with found low. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module equilibrium_index_finder_top #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [eif_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_final_element,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [eif_pkg::INDEX_W-1:0]   o_balance_index,
    output logic                          o_found,
    output logic                          o_run_end
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_ADDA = 3'd2;
    localparam logic [2:0] ST_ADDB = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    eif_pkg::t_sum         r_total, n_total;
    eif_pkg::t_sum         r_acc, n_acc;
    logic [AW-1:0]         r_idx, n_idx;
    logic                  r_pend_valid, n_pend_valid;
    logic [AW-1:0]         r_pend_idx, n_pend_idx;
    logic                  r_out_valid, n_out_valid;
    eif_pkg::t_index       r_out_index, n_out_index;
    logic                  r_out_found, n_out_found;
    logic                  r_out_end, n_out_end;

    logic                  wr_en;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    eif_pkg::t_sample      rd_data;
    eif_pkg::t_sum         op_a;
    eif_pkg::t_sum         op_b;
    eif_pkg::t_sum         sum;
    logic                  match;
    logic                  out_free;
    logic                  scan_last;

    eif_ram #(
        .WIDTH  (eif_pkg::SAMPLE_W),
        .DEPTH  (MAX_ELEMENTS),
        .ADDR_W (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_sample),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign op_a      = (r_state == ST_LOAD) ? r_total : r_acc;
    assign op_b      = (r_state == ST_LOAD) ?
                       {{(eif_pkg::SUM_W-eif_pkg::SAMPLE_W){i_sample[eif_pkg::SAMPLE_W-1]}},
                        i_sample} :
                       {{(eif_pkg::SUM_W-eif_pkg::SAMPLE_W){rd_data[eif_pkg::SAMPLE_W-1]}},
                        rd_data};
    assign sum       = op_a + op_b;
    assign match     = (sum == r_total);
    assign out_free  = !r_out_valid || !i_stall;
    assign scan_last = ((CW'(r_idx) + CW'(1)) == r_count);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_total      = r_total;
        n_acc        = r_acc;
        n_idx        = r_idx;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_out_valid  = r_out_valid && i_stall;
        n_out_index  = r_out_index;
        n_out_found  = r_out_found;
        n_out_end    = r_out_end;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = r_idx;

        case (r_state)
            ST_LOAD: begin
                if (i_valid) begin
                    if (r_count < CW'(MAX_ELEMENTS)) begin
                        wr_en   = 1'b1;
                        n_count = r_count + CW'(1);
                        n_total = sum;
                    end
                    if (i_final_element) begin
                        n_state      = ST_RD;
                        n_acc        = '0;
                        n_idx        = '0;
                        n_pend_valid = 1'b0;
                    end
                end
            end
            ST_RD: begin
                rd_en   = 1'b1;
                n_state = ST_ADDA;
            end
            ST_ADDA: begin
                // hold while an earlier match waits for a busy output
                if (!(match && r_pend_valid && !out_free)) begin
                    if (match) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_index = eif_pkg::INDEX_W'(r_pend_idx);
                            n_out_found = 1'b1;
                            n_out_end   = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_idx   = r_idx;
                    end
                    n_acc   = sum;
                    n_state = ST_ADDB;
                end
            end
            ST_ADDB: begin
                n_acc = sum;
                if (scan_last) begin
                    n_state = ST_FIN;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    rd_en   = 1'b1;
                    rd_addr = r_idx + AW'(1);
                    n_state = ST_ADDA;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_index = r_pend_valid ? eif_pkg::INDEX_W'(r_pend_idx) : '0;
                    n_out_found = r_pend_valid;
                    n_out_end   = 1'b1;
                    n_count     = '0;
                    n_total     = '0;
                    n_state     = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_count      <= '0;
            r_total      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_total      <= n_total;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc       <= n_acc;
        r_idx       <= n_idx;
        r_pend_idx  <= n_pend_idx;
        r_out_index <= n_out_index;
        r_out_found <= n_out_found;
        r_out_end   <= n_out_end;
    end

    assign o_stall         = (r_state != ST_LOAD);
    assign o_valid         = r_out_valid;
    assign o_balance_index = r_out_index;
    assign o_found         = r_out_found;
    assign o_run_end       = r_out_end;

endmodule

// ===== hdl/eif_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module eif_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
